// File: rtl/core/qst_pkg.sv
// Shared types, codes and constants of the CPU quiescence state tracker.
package qst_pkg;

  localparam int unsigned CPU_COUNT_DEF = 16;
  localparam longint unsigned STORE_COUNT_MAX_DEF = 64'd65535;

  localparam int unsigned OPCODE_W = 4;
  localparam int unsigned CPU_ID_W = 6;
  localparam int unsigned STATE_W = 3;
  localparam int unsigned PEND_W = 16;
  localparam int unsigned MASK_W = 16;
  localparam int unsigned ACT_CNT_W = 5;
  localparam int unsigned ACT_CNT_MAX = 31;

  typedef enum logic [OPCODE_W-1:0] {
    OP_HALT       = 4'd0,
    OP_WAIT       = 4'd1,
    OP_REQ_QUIES  = 4'd2,
    OP_SIGNAL     = 4'd3,
    OP_TRY_QUIES  = 4'd4,
    OP_ADD_STORE  = 4'd5,
    OP_DONE_STORE = 4'd6,
    OP_RESET      = 4'd7,
    OP_RESET_ALL  = 4'd8,
    OP_QUERY      = 4'd9
  } qst_opcode_e;

  typedef enum logic [1:0] {
    RUN_RUNNING  = 2'd0,
    RUN_HALTED   = 2'd1,
    RUN_WAITING  = 2'd2,
    RUN_QUIESCED = 2'd3
  } qst_run_e;

  // Reported state for a CPU number outside the configured range.
  localparam logic [STATE_W-1:0] CPU_STATE_RESET = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the incoming transaction
    logic rd_en;     // read the addressed CPU record
    logic exec;      // apply the opcode and write back
    logic load_out;  // move the result into the output register
  } qst_cmd_t;

endpackage

// File: rtl/core/qst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module qst_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/qst_ctrl.sv
// Controller state machine sequencing each transaction through the datapath.
module qst_ctrl
  import qst_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output qst_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_FINISH
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   slot_free;

  // The output register can take a new result when empty or being emptied.
  assign slot_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_READ;
          end
        end
        S_READ:  state_q <= S_EXEC;
        S_EXEC:  state_q <= S_FINISH;
        S_FINISH: begin
          if (slot_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase

      if ((state_q == S_FINISH) && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign cmd_o.capture    = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.rd_en      = (state_q == S_READ);
  assign cmd_o.exec       = (state_q == S_EXEC);
  assign cmd_o.load_out   = (state_q == S_FINISH) && slot_free;

endmodule

// File: rtl/core/qst_datapath.sv
// Datapath: CPU record store, shared masks, opcode update and result register.
module qst_datapath
  import qst_pkg::*;
#(
  parameter int unsigned     CPU_COUNT       = CPU_COUNT_DEF,
  parameter longint unsigned STORE_COUNT_MAX = STORE_COUNT_MAX_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  qst_cmd_t             cmd_i,
  input  logic [OPCODE_W-1:0]  opcode_i,
  input  logic [CPU_ID_W-1:0]  cpu_id_i,
  input  logic                 flag_i,
  output logic                 cpu_valid_o,
  output logic [STATE_W-1:0]   cpu_state_o,
  output logic [PEND_W-1:0]    pending_stores_o,
  output logic                 is_halted_o,
  output logic                 is_waiting_o,
  output logic                 is_quiescent_o,
  output logic [MASK_W-1:0]    active_mask_o,
  output logic [ACT_CNT_W-1:0] active_count_o,
  output logic                 store_underflow_o
);

  localparam int unsigned IdxW = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
  localparam int unsigned CntW = $clog2(STORE_COUNT_MAX + 64'd1);
  localparam int unsigned RecW = CntW + 3;
  localparam int unsigned PopW = $clog2(CPU_COUNT + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(STORE_COUNT_MAX);

  // Latched transaction.
  qst_opcode_e        op_q;
  logic [IdxW-1:0]    idx_q;
  logic               valid_q;
  logic               flag_q;

  // Per-CPU state held in flip-flops.
  logic [CPU_COUNT-1:0] halted_q, halted_d;
  logic [CPU_COUNT-1:0] waiting_q, waiting_d;
  logic [CPU_COUNT-1:0] rec_valid_q, rec_valid_d;

  // Result of the execute step, held until the output register takes it.
  logic               res_valid_q;
  logic [STATE_W-1:0] res_state_q;
  logic [PEND_W-1:0]  res_pend_q;
  logic               res_halted_q;
  logic               res_waiting_q;
  logic               res_quies_q;
  logic               res_uflow_q;

  // Output register.
  logic                 out_cpu_valid_q;
  logic [STATE_W-1:0]   out_state_q;
  logic [PEND_W-1:0]    out_pend_q;
  logic                 out_halted_q;
  logic                 out_waiting_q;
  logic                 out_quies_q;
  logic [MASK_W-1:0]    out_mask_q;
  logic [ACT_CNT_W-1:0] out_count_q;
  logic                 out_uflow_q;

  logic [RecW-1:0] rdata;
  logic [RecW-1:0] wdata;
  logic            ram_we;

  qst_run_e        st_old, st_new;
  logic            drain_old, drain_new;
  logic [CntW-1:0] cnt_old, cnt_new;
  logic            h_new, w_new, uflow;

  logic [CPU_COUNT-1:0] active;
  logic [PopW-1:0]      pop;
  logic [ACT_CNT_W-1:0] pop_sat;

  qst_ram #(
    .Width (RecW),
    .Depth (CPU_COUNT)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= qst_opcode_e'(opcode_i);
      idx_q   <= IdxW'(cpu_id_i);
      valid_q <= (32'(cpu_id_i) < CPU_COUNT);
      flag_q  <= flag_i;
    end
  end

  // A record never written since reset reads as running, no drain, no stores.
  always_comb begin
    if (rec_valid_q[idx_q]) begin
      st_old    = qst_run_e'(rdata[RecW-1 -: 2]);
      drain_old = rdata[CntW];
      cnt_old   = rdata[CntW-1:0];
    end else begin
      st_old    = RUN_RUNNING;
      drain_old = 1'b0;
      cnt_old   = '0;
    end
  end

  always_comb begin
    st_new    = st_old;
    drain_new = drain_old;
    cnt_new   = cnt_old;
    h_new     = halted_q[idx_q];
    w_new     = waiting_q[idx_q];
    uflow     = 1'b0;
    unique case (op_q)
      OP_HALT: begin
        h_new  = flag_q;
        st_new = flag_q ? RUN_HALTED : RUN_RUNNING;
      end
      OP_WAIT: begin
        w_new = flag_q;
        if (flag_q && (st_old == RUN_RUNNING)) begin
          st_new = RUN_WAITING;
        end else if (!flag_q && (st_old == RUN_WAITING)) begin
          st_new = RUN_RUNNING;
        end
      end
      OP_REQ_QUIES: drain_new = 1'b1;
      OP_SIGNAL: begin
        st_new    = RUN_QUIESCED;
        drain_new = 1'b0;
      end
      OP_TRY_QUIES: begin
        if (cnt_old == '0) begin
          st_new = RUN_QUIESCED;
        end
      end
      OP_ADD_STORE: begin
        if (cnt_old < CntMax) begin
          cnt_new = cnt_old + CntW'(1);
        end
      end
      OP_DONE_STORE: begin
        if (cnt_old == '0) begin
          uflow = 1'b1;
        end else begin
          cnt_new = cnt_old - CntW'(1);
          if ((cnt_old == CntW'(1)) && drain_old) begin
            st_new    = RUN_QUIESCED;
            drain_new = 1'b0;
          end
        end
      end
      OP_RESET, OP_RESET_ALL: begin
        st_new    = RUN_RUNNING;
        drain_new = 1'b0;
        cnt_new   = '0;
        h_new     = 1'b0;
        w_new     = 1'b0;
      end
      default: ;
    endcase
  end

  assign wdata  = {st_new, drain_new, cnt_new};
  assign ram_we = cmd_i.exec && valid_q && (op_q != OP_RESET_ALL);

  always_comb begin
    halted_d    = halted_q;
    waiting_d   = waiting_q;
    rec_valid_d = rec_valid_q;
    if (cmd_i.exec) begin
      if (op_q == OP_RESET_ALL) begin
        halted_d    = '0;
        waiting_d   = '0;
        rec_valid_d = '0;
      end else if (valid_q) begin
        halted_d[idx_q]    = h_new;
        waiting_d[idx_q]   = w_new;
        rec_valid_d[idx_q] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      halted_q    <= '0;
      waiting_q   <= '0;
      rec_valid_q <= '0;
    end else begin
      halted_q    <= halted_d;
      waiting_q   <= waiting_d;
      rec_valid_q <= rec_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_valid_q <= valid_q;
      if (valid_q) begin
        res_state_q   <= {1'b0, st_new};
        res_pend_q    <= PEND_W'(cnt_new);
        res_halted_q  <= h_new;
        res_waiting_q <= w_new;
        res_quies_q   <= (st_new == RUN_QUIESCED) && (cnt_new == '0);
        res_uflow_q   <= uflow;
      end else begin
        res_state_q   <= CPU_STATE_RESET;
        res_pend_q    <= '0;
        res_halted_q  <= 1'b0;
        res_waiting_q <= 1'b0;
        res_quies_q   <= 1'b0;
        res_uflow_q   <= 1'b0;
      end
    end
  end

  // Active CPUs and their count, taken from the masks after the update.
  assign active = ~(halted_q | waiting_q);

  always_comb begin
    pop = '0;
    for (int i = 0; i < CPU_COUNT; i++) begin
      pop = pop + PopW'(active[i]);
    end
    if (32'(pop) > ACT_CNT_MAX) begin
      pop_sat = ACT_CNT_W'(ACT_CNT_MAX);
    end else begin
      pop_sat = ACT_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_cpu_valid_q <= res_valid_q;
      out_state_q     <= res_state_q;
      out_pend_q      <= res_pend_q;
      out_halted_q    <= res_halted_q;
      out_waiting_q   <= res_waiting_q;
      out_quies_q     <= res_quies_q;
      out_mask_q      <= MASK_W'(active);
      out_count_q     <= pop_sat;
      out_uflow_q     <= res_uflow_q;
    end
  end

  assign cpu_valid_o       = out_cpu_valid_q;
  assign cpu_state_o       = out_state_q;
  assign pending_stores_o  = out_pend_q;
  assign is_halted_o       = out_halted_q;
  assign is_waiting_o      = out_waiting_q;
  assign is_quiescent_o    = out_quies_q;
  assign active_mask_o     = out_mask_q;
  assign active_count_o    = out_count_q;
  assign store_underflow_o = out_uflow_q;

endmodule

// File: rtl/core/cpu_quiescence_state_tracker.sv
// Top level of the CPU quiescence state tracker: controller plus datapath.
//
//   Channel  | Direction | Handshake                 | Payload
//   ---------+-----------+---------------------------+-----------------------------------
//   input    | in        | in_valid_i / in_stall_o   | opcode_i, cpu_id_i, flag_i
//   result   | out       | out_valid_o / out_stall_i | cpu_valid_o .. store_underflow_o
//
// A transaction is captured at its accepting edge and then passes through a record
// read, an execute step with write-back and a load step, which moves its result into
// the output register. The input stalls until that load is done and the controller
// is idle again, so a new transaction is never taken before the last one is through;
// the pace is set by the registered read of the per-CPU record RAM and the write-back
// that precedes the load of the result.
// An asynchronous active-low reset clears the controller, the halted and waiting
// masks and the per-record valid bits; the record RAM itself is not swept.
// While a result waits in the output register the next transaction is still
// accepted and processed, and it holds in its final step until the register frees.
//
// Every CPU keeps a run state, a drain-request flag and a pending-store count in a
// small RAM, one word per CPU, while the halted and waiting masks live in
// flip-flops so that the active mask is always at hand. A record whose valid bit is
// clear reads as the reset record (running, no drain, no stores), which lets the
// reset-all opcode clear every CPU at once by dropping the valid bits.
// A CPU number at or above the CPU count leaves all state untouched, except for
// reset-all, and reports the reset state with the per-CPU fields at zero.
module cpu_quiescence_state_tracker
  import qst_pkg::*;
#(
  parameter int unsigned     CPU_COUNT       = CPU_COUNT_DEF,
  parameter longint unsigned STORE_COUNT_MAX = STORE_COUNT_MAX_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [OPCODE_W-1:0]  opcode_i,
  input  logic [CPU_ID_W-1:0]  cpu_id_i,
  input  logic                 flag_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 cpu_valid_o,
  output logic [STATE_W-1:0]   cpu_state_o,
  output logic [PEND_W-1:0]    pending_stores_o,
  output logic                 is_halted_o,
  output logic                 is_waiting_o,
  output logic                 is_quiescent_o,
  output logic [MASK_W-1:0]    active_mask_o,
  output logic [ACT_CNT_W-1:0] active_count_o,
  output logic                 store_underflow_o
);

  // Command bundle from the sequencer to the datapath.
  qst_cmd_t cmd;

  qst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  qst_datapath #(
    .CPU_COUNT       (CPU_COUNT),
    .STORE_COUNT_MAX (STORE_COUNT_MAX)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .opcode_i          (opcode_i),
    .cpu_id_i          (cpu_id_i),
    .flag_i            (flag_i),
    .cpu_valid_o       (cpu_valid_o),
    .cpu_state_o       (cpu_state_o),
    .pending_stores_o  (pending_stores_o),
    .is_halted_o       (is_halted_o),
    .is_waiting_o      (is_waiting_o),
    .is_quiescent_o    (is_quiescent_o),
    .active_mask_o     (active_mask_o),
    .active_count_o    (active_count_o),
    .store_underflow_o (store_underflow_o)
  );

endmodule

// File: tb/tb.sv
// Self-checking testbench for the CPU quiescence state tracker.
module tb;
  import qst_pkg::*;

  // The block is built with its default sizes, and the predictor mirrors them.
  localparam int unsigned     NUM_CPUS     = CPU_COUNT_DEF;
  localparam longint unsigned STORE_CEIL   = STORE_COUNT_MAX_DEF;
  localparam int unsigned     RANDOM_ITEMS = 1280;
  localparam int unsigned     STORE_BURST  = 40;
  localparam int unsigned     CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned     IDLE_PCT     = 17;
  localparam int unsigned     CALM_FIRST   = 600;
  localparam int unsigned     CALM_LAST    = 900;
  localparam int unsigned     DRAIN_CYCLES = 16;
  localparam int unsigned     MAX_REPORTS  = 100;

  // Opcodes 10 to 15 carry no name in the package; the block treats them as a query.
  localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 4'd10;
  localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 4'd15;

  typedef struct {
    logic [OPCODE_W-1:0] opcode;
    logic [CPU_ID_W-1:0] cpu_id;
    logic                flag;
  } cpu_op_t;

  typedef struct packed {
    logic                 cpu_valid;
    logic [STATE_W-1:0]   cpu_state;
    logic [PEND_W-1:0]    pending_stores;
    logic                 is_halted;
    logic                 is_waiting;
    logic                 is_quiescent;
    logic [MASK_W-1:0]    active_mask;
    logic [ACT_CNT_W-1:0] active_count;
    logic                 store_underflow;
  } cpu_report_t;

  // Every input starts at a known value; reset is held from time zero.
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic [OPCODE_W-1:0]  opcode_i    = OP_QUERY;
  logic [CPU_ID_W-1:0]  cpu_id_i    = '0;
  logic                 flag_i      = 1'b0;
  logic                 out_stall_i = 1'b0;
  logic                 in_stall_o;
  logic                 out_valid_o;
  logic                 cpu_valid_o;
  logic [STATE_W-1:0]   cpu_state_o;
  logic [PEND_W-1:0]    pending_stores_o;
  logic                 is_halted_o;
  logic                 is_waiting_o;
  logic                 is_quiescent_o;
  logic [MASK_W-1:0]    active_mask_o;
  logic [ACT_CNT_W-1:0] active_count_o;
  logic                 store_underflow_o;

  cpu_op_t     op_queue[$];
  cpu_report_t expected_reports[$];

  int unsigned cycle_count    = 0;
  int unsigned sent_count     = 0;
  int unsigned received_count = 0;
  int unsigned fault_count    = 0;
  int unsigned absent_hits    = 0;
  int unsigned underflow_hits = 0;
  int unsigned ceiling_hits   = 0;
  int unsigned drain_hits     = 0;

  // The predictor's own copy of the per-CPU records and the shared masks.
  qst_run_e          run_state   [NUM_CPUS];
  longint unsigned   store_count [NUM_CPUS];
  logic              drain_req   [NUM_CPUS];
  logic [MASK_W-1:0] halted_bits;
  logic [MASK_W-1:0] waiting_bits;

  cpu_quiescence_state_tracker dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .opcode_i          (opcode_i),
    .cpu_id_i          (cpu_id_i),
    .flag_i            (flag_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .cpu_valid_o       (cpu_valid_o),
    .cpu_state_o       (cpu_state_o),
    .pending_stores_o  (pending_stores_o),
    .is_halted_o       (is_halted_o),
    .is_waiting_o      (is_waiting_o),
    .is_quiescent_o    (is_quiescent_o),
    .active_mask_o     (active_mask_o),
    .active_count_o    (active_count_o),
    .store_underflow_o (store_underflow_o)
  );

  always #6 clk_i = ~clk_i;

  // A CPU record returns to running with no drain request, no stores and both mask bits clear.
  function automatic void clear_cpu_record(int unsigned c);
    halted_bits[c]  = 1'b0;
    waiting_bits[c] = 1'b0;
    drain_req[c]    = 1'b0;
    store_count[c]  = 0;
    run_state[c]    = RUN_RUNNING;
  endfunction

  function automatic void clear_all_records();
    for (int unsigned i = 0; i < NUM_CPUS; i++) begin
      clear_cpu_record(i);
    end
  endfunction

  // Applies one transaction to the predicted records and returns the report that the
  // block must give for it: the addressed CPU after the update, plus the active mask and count.
  function automatic cpu_report_t apply_cpu_op(logic [OPCODE_W-1:0] op,
                                               logic [CPU_ID_W-1:0] id, logic flag);
    cpu_report_t       rep;
    logic              present;
    logic              underflow;
    logic [MASK_W-1:0] active;
    int unsigned       ones;
    int unsigned       c;
    rep       = '0;
    present   = (id < NUM_CPUS);
    underflow = 1'b0;
    c         = id;
    if (op == OP_RESET_ALL) begin
      // Reset-all acts whatever the CPU number is.
      clear_all_records();
    end else if (present) begin
      case (op)
        OP_HALT: begin
          halted_bits[c] = flag;
          run_state[c]   = flag ? RUN_HALTED : RUN_RUNNING;
        end
        OP_WAIT: begin
          waiting_bits[c] = flag;
          if (flag && run_state[c] == RUN_RUNNING) begin
            run_state[c] = RUN_WAITING;
          end else if (!flag && run_state[c] == RUN_WAITING) begin
            run_state[c] = RUN_RUNNING;
          end
        end
        OP_REQ_QUIES: begin
          drain_req[c] = 1'b1;
        end
        OP_SIGNAL: begin
          run_state[c] = RUN_QUIESCED;
          drain_req[c] = 1'b0;
        end
        OP_TRY_QUIES: begin
          if (store_count[c] == 0) begin
            run_state[c] = RUN_QUIESCED;
          end
        end
        OP_ADD_STORE: begin
          if (store_count[c] < STORE_CEIL) begin
            store_count[c]++;
          end else begin
            ceiling_hits++;
          end
        end
        OP_DONE_STORE: begin
          if (store_count[c] == 0) begin
            underflow = 1'b1;
            underflow_hits++;
          end else begin
            store_count[c]--;
            // The last outstanding store of a draining CPU completes the drain.
            if (store_count[c] == 0 && drain_req[c]) begin
              run_state[c] = RUN_QUIESCED;
              drain_req[c] = 1'b0;
              drain_hits++;
            end
          end
        end
        OP_RESET: begin
          clear_cpu_record(c);
        end
        default: begin
        end
      endcase
    end
    if (!present) begin
      absent_hits++;
    end

    active = ~(halted_bits | waiting_bits);
    ones   = $countones(active);
    if (ones > ACT_CNT_MAX) begin
      ones = ACT_CNT_MAX;
    end
    rep.active_mask  = active;
    rep.active_count = ones[ACT_CNT_W-1:0];
    if (present) begin
      rep.cpu_valid       = 1'b1;
      rep.cpu_state       = {1'b0, run_state[c]};
      rep.pending_stores  = store_count[c][PEND_W-1:0];
      rep.is_halted       = halted_bits[c];
      rep.is_waiting      = waiting_bits[c];
      rep.is_quiescent    = (run_state[c] == RUN_QUIESCED && store_count[c] == 0);
      rep.store_underflow = underflow;
    end else begin
      rep.cpu_state = CPU_STATE_RESET;
    end
    return rep;
  endfunction

  task automatic push_op(logic [OPCODE_W-1:0] op, logic [CPU_ID_W-1:0] id, logic flag);
    cpu_op_t item;
    item.opcode = op;
    item.cpu_id = id;
    item.flag   = flag;
    op_queue.push_back(item);
  endtask

  // Reports one differing field. Only the first hundred are printed so that a badly
  // broken block cannot flood the log; every one of them still counts as a fault.
  task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fault_count++;
      if (fault_count <= MAX_REPORTS) begin
        $display("%0t: %s differs, expected %0h, actual %0h", $time, field, want, got);
      end
    end
  endtask

  // Both sides idle at random, except in a window of transactions where they run flat out.
  function automatic logic idle_now(int unsigned done_count);
    if (done_count >= CALM_FIRST && done_count < CALM_LAST) begin
      return 1'b0;
    end
    return ($urandom_range(0, 99) < IDLE_PCT);
  endfunction

  // Driver. When a transaction is accepted its expected report is predicted from the
  // values on the ports at that edge. A stalled transaction is held unchanged; otherwise
  // the next one is offered unless this cycle is an idle one.
  always @(posedge clk_i or negedge rst_ni) begin
    cpu_op_t next_op;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      opcode_i   <= OP_QUERY;
      cpu_id_i   <= '0;
      flag_i     <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_reports.push_back(apply_cpu_op(opcode_i, cpu_id_i, flag_i));
        sent_count++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (op_queue.size() != 0 && !idle_now(sent_count)) begin
          next_op = op_queue.pop_front();
          in_valid_i <= 1'b1;
          opcode_i   <= next_op.opcode;
          cpu_id_i   <= next_op.cpu_id;
          flag_i     <= next_op.flag;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor. Each accepted report is checked field by field against the oldest
  // prediction; the stall is redrawn every cycle.
  always @(posedge clk_i or negedge rst_ni) begin
    cpu_report_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        received_count++;
        if (expected_reports.size() == 0) begin
          fault_count++;
          $display("%0t: report with no transaction waiting, expected none, actual mask %0h",
                   $time, active_mask_o);
        end else begin
          want = expected_reports.pop_front();
          compare_field("cpu_valid", want.cpu_valid, cpu_valid_o);
          compare_field("cpu_state", want.cpu_state, cpu_state_o);
          compare_field("pending_stores", want.pending_stores, pending_stores_o);
          compare_field("is_halted", want.is_halted, is_halted_o);
          compare_field("is_waiting", want.is_waiting, is_waiting_o);
          compare_field("is_quiescent", want.is_quiescent, is_quiescent_o);
          compare_field("active_mask", want.active_mask, active_mask_o);
          compare_field("active_count", want.active_count, active_count_o);
          compare_field("store_underflow", want.store_underflow, store_underflow_o);
        end
      end
      out_stall_i <= idle_now(received_count);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int unsigned         target;
    int unsigned         depth;
    int unsigned         drain_at;
    logic [CPU_ID_W-1:0] cpu;
    logic [OPCODE_W-1:0] op;
    clear_all_records();

    // Directed part: extremes of the CPU number, every opcode and the special cases.
    push_op(OP_QUERY, 0, 1'b0);                          // state straight after reset
    push_op(OP_DONE_STORE, 0, 1'b1);                     // completion with nothing pending
    push_op(OP_HALT, CPU_ID_W'(NUM_CPUS - 1), 1'b1);     // highest CPU that exists
    push_op(OP_WAIT, CPU_ID_W'(NUM_CPUS - 1), 1'b1);     // halted CPU keeps its state
    push_op(OP_HALT, CPU_ID_W'(NUM_CPUS - 1), 1'b0);     // running again, waiting bit set
    push_op(OP_WAIT, CPU_ID_W'(NUM_CPUS - 1), 1'b0);
    push_op(OP_WAIT, 3, 1'b1);                           // running CPU starts waiting
    push_op(OP_HALT, CPU_ID_W'(NUM_CPUS), 1'b1);         // first absent CPU is ignored
    push_op(OP_ADD_STORE, 40, 1'b0);                     // absent CPU again
    push_op(OP_QUERY, '1, 1'b1);                         // highest CPU number of all
    push_op(OP_ADD_STORE, 2, 1'b0);
    push_op(OP_ADD_STORE, 2, 1'b0);
    push_op(OP_REQ_QUIES, 2, 1'b0);
    push_op(OP_TRY_QUIES, 2, 1'b0);                      // stores outstanding, no change
    push_op(OP_DONE_STORE, 2, 1'b0);
    push_op(OP_DONE_STORE, 2, 1'b0);                     // last store ends the drain
    push_op(OP_TRY_QUIES, 1, 1'b0);                      // nothing pending, quiesces at once
    push_op(OP_SIGNAL, 4, 1'b1);
    push_op(OP_RESET, 3, 1'b0);
    push_op(OP_SPARE_HI, 5, 1'b1);                       // unused opcodes behave as a query
    push_op(OP_SPARE_LO, 0, 1'b0);
    push_op(OP_ADD_STORE, 0, 1'b1);
    push_op(OP_RESET_ALL, '1, 1'b0);                     // acts even with an absent CPU
    push_op(OP_QUERY, 2, 1'b0);

    // Random part. Most of it is drain sequences on one CPU (stores registered, a drain
    // requested somewhere among them, mask changes mixed in, then the stores completed),
    // so that the quiesce-on-last-store path is reached often. The rest is loose
    // transactions over the whole opcode and CPU number range.
    target = op_queue.size() + RANDOM_ITEMS;
    while (op_queue.size() < target) begin
      if ($urandom_range(0, 9) < 7) begin
        cpu      = CPU_ID_W'($urandom_range(0, NUM_CPUS - 1));
        depth    = $urandom_range(1, 6);
        drain_at = $urandom_range(0, depth + 1);   // past the end means no drain request
        for (int unsigned k = 0; k < depth; k++) begin
          if (k == drain_at) begin
            push_op(OP_REQ_QUIES, cpu, 1'($urandom_range(0, 1)));
          end
          push_op(OP_ADD_STORE, cpu, 1'($urandom_range(0, 1)));
          if ($urandom_range(0, 3) == 0) begin
            push_op($urandom_range(0, 1) ? OP_HALT : OP_WAIT, cpu,
                    1'($urandom_range(0, 1)));
          end
        end
        if ($urandom_range(0, 3) == 0) begin
          push_op(OP_TRY_QUIES, cpu, 1'($urandom_range(0, 1)));
        end
        for (int unsigned k = 0; k < depth; k++) begin
          push_op(OP_DONE_STORE, cpu, 1'($urandom_range(0, 1)));
          if ($urandom_range(0, 4) == 0) begin
            push_op(OP_QUERY, cpu, 1'($urandom_range(0, 1)));
          end
        end
        if ($urandom_range(0, 4) == 0) begin
          push_op(OP_DONE_STORE, cpu, 1'($urandom_range(0, 1)));
        end
        if ($urandom_range(0, 5) == 0) begin
          push_op($urandom_range(0, 1) ? OP_SIGNAL : OP_RESET, cpu,
                  1'($urandom_range(0, 1)));
        end
      end else begin
        op = OPCODE_W'($urandom_range(0, 15));
        // Reset-all wipes every record, so most draws of it become a query.
        if (op == OP_RESET_ALL && $urandom_range(0, 3) != 0) begin
          op = OP_QUERY;
        end
        if ($urandom_range(0, 4) == 0) begin
          cpu = CPU_ID_W'($urandom_range(NUM_CPUS, 63));
        end else begin
          cpu = CPU_ID_W'($urandom_range(0, NUM_CPUS - 1));
        end
        push_op(op, cpu, 1'($urandom_range(0, 1)));
      end
    end

    // A long run of registrations on one CPU builds a deep pending count, which is then
    // taken down by one under a drain request and finally cleared.
    cpu = CPU_ID_W'($urandom_range(0, NUM_CPUS - 1));
    for (int unsigned k = 0; k < STORE_BURST; k++) begin
      push_op(OP_ADD_STORE, cpu, k[0]);
    end
    push_op(OP_DONE_STORE, cpu, 1'b0);
    push_op(OP_ADD_STORE, cpu, 1'b0);
    push_op(OP_REQ_QUIES, cpu, 1'b0);
    push_op(OP_DONE_STORE, cpu, 1'b1);
    push_op(OP_RESET, cpu, 1'b0);
    push_op(OP_QUERY, cpu, 1'b0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait until every transaction has gone in and every report has come out, then
    // keep watching the outputs in case the block produces anything unasked for.
    while (op_queue.size() != 0 || in_valid_i || expected_reports.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Checked %0d reports from %0d transactions in %0d cycles.",
             received_count, sent_count, cycle_count);
    $display("Absent CPUs %0d, underflows %0d, completed drains %0d, ceiling hits %0d.",
             absent_hits, underflow_hits, drain_hits, ceiling_hits);
    if (fault_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
